[rtl/btndbc_pkg.sv]
package btndbc_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE    = 2'd0,
        OP_TAKE_RISE = 2'd1,
        OP_TAKE_FELL = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    typedef enum logic {
        REG_DOUBLE_LIMIT = 1'b0,
        REG_LONG_LIMIT   = 1'b1
    } reg_idx_t;

    localparam int CNT_W = 8;

    localparam logic [CNT_W-1:0] GAP_EXTRA          = 8'd20;
    localparam logic [CNT_W:0]   COUNT_WRAP         = 9'd255;
    localparam logic [CNT_W-1:0] COUNT_MAX          = 8'd254;
    localparam logic [CNT_W-1:0] DOUBLE_LIMIT_RESET = 8'd40;
    localparam logic [CNT_W-1:0] LONG_LIMIT_RESET   = 8'd100;

    typedef struct packed {
        logic [CNT_W-1:0] double_limit;
        logic [CNT_W-1:0] long_limit;
    } cfg_t;

    typedef struct packed {
        logic long_press;
        logic double_click;
        logic fell_seen;
        logic rise_seen;
        logic pressed;
        logic stable;
    } result_t;

endpackage

[rtl/btndbc_regs.sv]
module btndbc_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output btndbc_pkg::cfg_t    cfg
);

    logic [btndbc_pkg::CNT_W-1:0] double_limit_reg;
    logic [btndbc_pkg::CNT_W-1:0] long_limit_reg;
    logic                         wr_en;
    btndbc_pkg::reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = btndbc_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            double_limit_reg <= btndbc_pkg::DOUBLE_LIMIT_RESET;
            long_limit_reg   <= btndbc_pkg::LONG_LIMIT_RESET;
        end else if (wr_en) begin
            unique case (idx)
                btndbc_pkg::REG_DOUBLE_LIMIT: double_limit_reg <= pwdata[7:0];
                btndbc_pkg::REG_LONG_LIMIT:   long_limit_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            btndbc_pkg::REG_DOUBLE_LIMIT: prdata = {24'd0, double_limit_reg};
            btndbc_pkg::REG_LONG_LIMIT:   prdata = {24'd0, long_limit_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    assign cfg.double_limit = double_limit_reg;
    assign cfg.long_limit   = long_limit_reg;

endmodule

[rtl/btndbc_core.sv]
module btndbc_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  btndbc_pkg::op_t        op,
    input  logic                   pin_level,
    input  btndbc_pkg::cfg_t       cfg,
    output btndbc_pkg::result_t    result
);

    localparam int W = btndbc_pkg::CNT_W;

    logic         last_reg,   last_next;
    logic         older_reg,  older_next;
    logic         level_reg,  level_next;
    logic [W-1:0] on_reg,     on_next;
    logic [W-1:0] off_reg,    off_next;
    logic         rise_reg,   rise_next;
    logic         fell_reg,   fell_next;
    logic         double_reg, double_next;
    logic         long_reg,   long_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg   <= 1'b0;
            older_reg  <= 1'b0;
            level_reg  <= 1'b0;
            on_reg     <= '0;
            off_reg    <= '0;
            rise_reg   <= 1'b0;
            fell_reg   <= 1'b0;
            double_reg <= 1'b0;
            long_reg   <= 1'b0;
        end else if (en) begin
            last_reg   <= last_next;
            older_reg  <= older_next;
            level_reg  <= level_next;
            on_reg     <= on_next;
            off_reg    <= off_next;
            rise_reg   <= rise_next;
            fell_reg   <= fell_next;
            double_reg <= double_next;
            long_reg   <= long_next;
        end
    end

    always_comb begin
        logic       closed;
        logic [W:0] cnt;
        logic       rise_mid;
        logic       fell_mid;

        closed      = ~pin_level;
        cnt         = '0;
        last_next   = last_reg;
        older_next  = older_reg;
        level_next  = level_reg;
        on_next     = on_reg;
        off_next    = off_reg;
        rise_mid    = rise_reg;
        fell_mid    = fell_reg;
        double_next = double_reg;
        long_next   = long_reg;

        unique case (op)
            btndbc_pkg::OP_SAMPLE: begin
                if (closed == last_reg) begin
                    if (closed) begin
                        cnt        = {1'b0, on_reg} + (W+1)'(1);
                        level_next = 1'b1;
                        if (!older_reg) begin
                            rise_mid = 1'b1;
                            if (({1'b0, off_reg} < ({1'b0, cfg.double_limit}
                                    + {1'b0, btndbc_pkg::GAP_EXTRA}))
                                    && (cnt < {1'b0, cfg.double_limit})) begin
                                double_next = 1'b1;
                            end
                            cnt = '0;
                        end
                        if (cnt > {1'b0, cfg.long_limit}) begin
                            long_next = 1'b1;
                        end
                        on_next = (cnt == btndbc_pkg::COUNT_WRAP) ?
                                  btndbc_pkg::COUNT_MAX : cnt[W-1:0];
                    end else begin
                        cnt        = {1'b0, off_reg} + (W+1)'(1);
                        level_next = 1'b0;
                        if (older_reg) begin
                            fell_mid = 1'b1;
                            cnt      = '0;
                        end
                        off_next = (cnt == btndbc_pkg::COUNT_WRAP) ?
                                   btndbc_pkg::COUNT_MAX : cnt[W-1:0];
                    end
                end
                older_next = last_reg;
                last_next  = closed;
            end
            btndbc_pkg::OP_CLEAR: begin
                on_next     = '0;
                off_next    = '0;
                rise_mid    = 1'b0;
                fell_mid    = 1'b0;
                double_next = 1'b0;
                long_next   = 1'b0;
            end
            default: ;
        endcase

        rise_next = (op == btndbc_pkg::OP_TAKE_RISE) ? 1'b0 : rise_mid;
        fell_next = (op == btndbc_pkg::OP_TAKE_FELL) ? 1'b0 : fell_mid;

        result.stable       = (last_next == older_next);
        result.pressed      = level_next;
        result.rise_seen    = rise_mid;
        result.fell_seen    = fell_mid;
        result.double_click = double_next;
        result.long_press   = long_next;
    end

endmodule

[rtl/button_debounce_click_detector_top.sv]
// button debouncer with click, double click and long press detection
// s_ channel: one word per command; tdata carries the operation and the raw
// active-low pin level. operation 0 samples the pin, 1 reads and clears the
// rise flag, 2 reads and clears the fell flag, 3 clears counters and flags.
// m_ channel: exactly one result word per command, in command order, with
// the debounced level, the stable bit and the four flags.
// apb port: double click limit at 0x0, long press limit at 0x4; write only
// while no command is in flight.
// flow: an accepted word waits in the input register until the output
// register is free or being read, then is processed by the core and its
// result is registered into the output register and offered on m_.
// throughput: one word per cycle unless m_ stalls, set by the single
// state update stage. a stalled m_ side holds its word; the input register
// can still take one more word, after which s_tready drops until m_tready
// returns. reset clears the sample history, counters and flags and empties
// both pipeline stages; the limits return to 40 and 100.
module button_debounce_click_detector_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // operation[1:0], pin_level[2], zero[7:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // stable, pressed, rise_seen, fell_seen,
                                   // double_click, long_press, zero[7:6]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    btndbc_pkg::cfg_t    cfg;
    btndbc_pkg::result_t result;

    logic                in_valid_reg;
    btndbc_pkg::op_t     op_reg;
    logic                pin_reg;
    logic                out_valid_reg;
    btndbc_pkg::result_t out_reg;
    logic                advance;
    logic                s_accept;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    btndbc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    btndbc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .op        (op_reg),
        .pin_level (pin_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= btndbc_pkg::op_t'(s_tdata[1:0]);
            pin_reg <= s_tdata[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.long_press, out_reg.double_click,
                       out_reg.fell_seen, out_reg.rise_seen,
                       out_reg.pressed, out_reg.stable};

`ifndef SYNTHESIS
    a_clear_zeroes_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && op_reg == btndbc_pkg::OP_CLEAR
        |=> !out_reg.rise_seen && !out_reg.fell_seen
            && !out_reg.double_click && !out_reg.long_press)
        else $error("clear left a flag set");

    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !advance)
        else $error("result overwritten while stalled");
`endif

endmodule
